// File: hdl/bis_pkg.sv
// Shared types, register codes and size constants of the bilinear image scaler.
package bis_pkg;

	localparam int DEF_MAX_SIDE    = 256;
	localparam int DEF_WEIGHT_BITS = 8;

	localparam int SRC_CFG_W    = 9;
	localparam int DST_CFG_W    = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int COORD_W      = 12;
	localparam int LOAD_COORD_W = 8;
	localparam int PIX_W        = 32;
	localparam int CHAN_W       = 8;
	localparam int CHANS        = 4;

	localparam logic [SRC_CFG_W-1:0] SRC_SIZE_RST = 9'd256;
	localparam logic [DST_CFG_W-1:0] DST_SIZE_RST = 13'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_DST_WIDTH  = 2'd2,
		CFG_DST_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		MODE_LOAD   = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

	typedef struct packed {
		logic [SRC_CFG_W-1:0] src_width;
		logic [SRC_CFG_W-1:0] src_height;
		logic [DST_CFG_W-1:0] dst_width;
		logic [DST_CFG_W-1:0] dst_height;
	} cfg_t;

	typedef struct packed {
		mode_t                   mode;
		logic [LOAD_COORD_W-1:0] load_x;
		logic [LOAD_COORD_W-1:0] load_y;
		logic [PIX_W-1:0]        load_pixel;
	} load_t;

endpackage

// File: hdl/bis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/bis_map.sv
// Coordinate mapper: scale multiply, pipelined restoring divide, clamp to index and weight.
module bis_map #(
	parameter int MAX_SIDE    = bis_pkg::DEF_MAX_SIDE,
	parameter int WEIGHT_BITS = bis_pkg::DEF_WEIGHT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_vld,
	input  bis_pkg::load_t                    in_load,
	input  logic [bis_pkg::COORD_W-1:0]       in_out_x,
	input  logic [bis_pkg::COORD_W-1:0]       in_out_y,
	input  bis_pkg::cfg_t                     cfg,
	output logic                              map_vld,
	output bis_pkg::load_t                    map_load,
	output logic [$clog2(MAX_SIDE)-1:0]       x0,
	output logic [$clog2(MAX_SIDE)-1:0]       x1,
	output logic [WEIGHT_BITS-1:0]            wx,
	output logic [$clog2(MAX_SIDE)-1:0]       y0,
	output logic [$clog2(MAX_SIDE)-1:0]       y1,
	output logic [WEIGHT_BITS-1:0]            wy
);

	import bis_pkg::*;

	localparam int CW  = $clog2(MAX_SIDE);
	localparam int SW  = $clog2(MAX_SIDE + 1);
	localparam int PW  = CW + WEIGHT_BITS;
	localparam int PRW = COORD_W + SW;
	localparam int OW  = PRW - CW;
	localparam int CMW = (OW > DST_CFG_W) ? OW : DST_CFG_W;
	localparam int NW  = PRW + WEIGHT_BITS;
	localparam int RW  = (NW > DST_CFG_W + PW) ? NW : DST_CFG_W + PW;

	function automatic logic [SW-1:0] clamp_src(input logic [SRC_CFG_W-1:0] v);
		if (v == '0) begin
			return SW'(1);
		end else if (32'(v) > MAX_SIDE) begin
			return SW'(MAX_SIDE);
		end
		return SW'(v);
	endfunction

	logic [SW-1:0]        src_w_eff, src_h_eff;
	logic [DST_CFG_W-1:0] dst_w_eff, dst_h_eff;

	assign src_w_eff = clamp_src(cfg.src_width);
	assign src_h_eff = clamp_src(cfg.src_height);
	assign dst_w_eff = (cfg.dst_width == '0) ? DST_CFG_W'(1) : cfg.dst_width;
	assign dst_h_eff = (cfg.dst_height == '0) ? DST_CFG_W'(1) : cfg.dst_height;

	// scale multiply stage
	logic           vld_s1;
	load_t          load_s1;
	logic [PRW-1:0] prod_x_s1, prod_y_s1;

	// divider stages, entry 0 holds the initial remainder and overflow flag
	logic          vld_sd   [0:PW];
	load_t         load_sd  [0:PW];
	logic [RW-1:0] rem_x_sd [0:PW];
	logic [RW-1:0] rem_y_sd [0:PW];
	logic [PW-1:0] q_x_sd   [0:PW];
	logic [PW-1:0] q_y_sd   [0:PW];
	logic          ov_x_sd  [0:PW];
	logic          ov_y_sd  [0:PW];

	logic [RW-1:0] rem_x_nx [1:PW];
	logic [RW-1:0] rem_y_nx [1:PW];
	logic [PW-1:0] q_x_nx   [1:PW];
	logic [PW-1:0] q_y_nx   [1:PW];

	// clamp stage outputs
	logic           vld_s2;
	load_t          load_s2;
	logic [CW-1:0]  x0_s2, x1_s2, y0_s2, y1_s2;
	logic [WEIGHT_BITS-1:0] wx_s2, wy_s2;

	always_comb begin
		logic [RW-1:0] dvx;
		logic [RW-1:0] dvy;
		for (int j = 1; j <= PW; j++) begin
			dvx = RW'(dst_w_eff) << (PW - j);
			dvy = RW'(dst_h_eff) << (PW - j);
			rem_x_nx[j] = (rem_x_sd[j-1] >= dvx) ? rem_x_sd[j-1] - dvx : rem_x_sd[j-1];
			rem_y_nx[j] = (rem_y_sd[j-1] >= dvy) ? rem_y_sd[j-1] - dvy : rem_y_sd[j-1];
			q_x_nx[j] = q_x_sd[j-1] | (PW'(rem_x_sd[j-1] >= dvx) << (PW - j));
			q_y_nx[j] = q_y_sd[j-1] | (PW'(rem_y_sd[j-1] >= dvy) << (PW - j));
		end
	end

	logic [PW-1:0] top_x, top_y, pos_x, pos_y;
	logic [CW-1:0] last_x, last_y, i0x, i0y;

	always_comb begin
		top_x  = PW'(src_w_eff - SW'(1)) << WEIGHT_BITS;
		top_y  = PW'(src_h_eff - SW'(1)) << WEIGHT_BITS;
		pos_x  = (ov_x_sd[PW] || q_x_sd[PW] > top_x) ? top_x : q_x_sd[PW];
		pos_y  = (ov_y_sd[PW] || q_y_sd[PW] > top_y) ? top_y : q_y_sd[PW];
		last_x = CW'(src_w_eff - SW'(1));
		last_y = CW'(src_h_eff - SW'(1));
		i0x    = CW'(pos_x >> WEIGHT_BITS);
		i0y    = CW'(pos_y >> WEIGHT_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int j = 0; j <= PW; j++) begin
				vld_sd[j] <= 1'b0;
			end
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_vld;
			vld_sd[0] <= vld_s1;
			for (int j = 1; j <= PW; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
			vld_s2 <= vld_sd[PW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			load_s1   <= in_load;
			prod_x_s1 <= PRW'(in_out_x) * PRW'(src_w_eff);
			prod_y_s1 <= PRW'(in_out_y) * PRW'(src_h_eff);

			// quotient overflows the position range when num >= dst << PW
			load_sd[0]  <= load_s1;
			rem_x_sd[0] <= RW'(prod_x_s1) << WEIGHT_BITS;
			rem_y_sd[0] <= RW'(prod_y_s1) << WEIGHT_BITS;
			q_x_sd[0]   <= '0;
			q_y_sd[0]   <= '0;
			ov_x_sd[0]  <= CMW'(prod_x_s1 >> CW) >= CMW'(dst_w_eff);
			ov_y_sd[0]  <= CMW'(prod_y_s1 >> CW) >= CMW'(dst_h_eff);

			for (int j = 1; j <= PW; j++) begin
				load_sd[j]  <= load_sd[j-1];
				rem_x_sd[j] <= rem_x_nx[j];
				rem_y_sd[j] <= rem_y_nx[j];
				q_x_sd[j]   <= q_x_nx[j];
				q_y_sd[j]   <= q_y_nx[j];
				ov_x_sd[j]  <= ov_x_sd[j-1];
				ov_y_sd[j]  <= ov_y_sd[j-1];
			end

			// saturate to the last column or row, neighbour clamps at the edge
			load_s2 <= load_sd[PW];
			x0_s2   <= i0x;
			y0_s2   <= i0y;
			x1_s2   <= (i0x == last_x) ? i0x : i0x + CW'(1);
			y1_s2   <= (i0y == last_y) ? i0y : i0y + CW'(1);
			wx_s2   <= pos_x[WEIGHT_BITS-1:0];
			wy_s2   <= pos_y[WEIGHT_BITS-1:0];
		end
	end

	assign map_vld  = vld_s2;
	assign map_load = load_s2;
	assign x0       = x0_s2;
	assign x1       = x1_s2;
	assign wx       = wx_s2;
	assign y0       = y0_s2;
	assign y1       = y1_s2;
	assign wy       = wy_s2;

	a_neighbour_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && load_s2.mode == MODE_SAMPLE) |->
		((x1_s2 == x0_s2 || x1_s2 == x0_s2 + CW'(1)) &&
		 (y1_s2 == y0_s2 || y1_s2 == y0_s2 + CW'(1))))
		else $error("neighbour index is neither the base nor the next one");

	a_weight_has_neighbour: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && load_s2.mode == MODE_SAMPLE && wx_s2 != '0) |-> (x1_s2 == x0_s2 + CW'(1)))
		else $error("non-zero column weight at a clamped column");

endmodule

// File: hdl/bis_blend.sv
// Parity-banked source store with load writes, four-neighbour fetch and per-channel blend.
module bis_blend #(
	parameter int MAX_SIDE    = bis_pkg::DEF_MAX_SIDE,
	parameter int WEIGHT_BITS = bis_pkg::DEF_WEIGHT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          map_vld,
	input  bis_pkg::load_t                map_load,
	input  logic [$clog2(MAX_SIDE)-1:0]   x0,
	input  logic [$clog2(MAX_SIDE)-1:0]   x1,
	input  logic [WEIGHT_BITS-1:0]        wx,
	input  logic [$clog2(MAX_SIDE)-1:0]   y0,
	input  logic [$clog2(MAX_SIDE)-1:0]   y1,
	input  logic [WEIGHT_BITS-1:0]        wy,
	output logic                          res_vld,
	output logic [bis_pkg::PIX_W-1:0]     res_pixel
);

	import bis_pkg::*;

	localparam int CW    = $clog2(MAX_SIDE);
	localparam int HW    = (CW > 1) ? CW - 1 : 1;
	localparam int AW    = 2 * HW;
	localparam int DEPTH = 1 << AW;
	localparam int ONE_W = 1 << WEIGHT_BITS;
	localparam int WW    = WEIGHT_BITS + 1;
	localparam int PA    = CHAN_W + WEIGHT_BITS + 1;
	localparam int FW    = CHAN_W + 2 * WEIGHT_BITS + 2;

	logic          ld_ok, rd_smp;
	logic [1:0]    wr_bank;
	logic [AW-1:0] wr_addr;
	logic [HW-1:0] col_a [2];
	logic [HW-1:0] row_a [2];
	logic [PIX_W-1:0] bank_q [4];

	assign ld_ok   = map_vld && map_load.mode == MODE_LOAD &&
		32'(map_load.load_x) < MAX_SIDE && 32'(map_load.load_y) < MAX_SIDE;
	assign rd_smp  = map_vld && map_load.mode == MODE_SAMPLE;
	assign wr_bank = {map_load.load_y[0], map_load.load_x[0]};
	assign wr_addr = {HW'(map_load.load_y[LOAD_COORD_W-1:1]),
		HW'(map_load.load_x[LOAD_COORD_W-1:1])};

	// each parity bank serves exactly one of the two columns and one of the two rows
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			col_a[p] = (x0[0] == 1'(p)) ? HW'(x0 >> 1) : HW'(x1 >> 1);
			row_a[p] = (y0[0] == 1'(p)) ? HW'(y0 >> 1) : HW'(y1 >> 1);
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam int PY = b / 2;
		localparam int PX = b % 2;
		bis_ram #(
			.WIDTH (PIX_W),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (adv && ld_ok && wr_bank == 2'(b)),
			.waddr (wr_addr),
			.wdata (map_load.load_pixel),
			.re    (adv && rd_smp),
			.raddr ({row_a[PY], col_a[PX]}),
			.rdata (bank_q[b])
		);
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic x0p_s1, x1p_s1, y0p_s1, y1p_s1;
	logic [WEIGHT_BITS-1:0] wx_s1, wy_s1, wy_s2, wy_s3;
	logic [PA-1:0] pa_s2 [CHANS];
	logic [PA-1:0] pb_s2 [CHANS];
	logic [PA-1:0] pd_s2 [CHANS];
	logic [PA-1:0] pe_s2 [CHANS];
	logic [PA-1:0] row0_s3 [CHANS];
	logic [PA-1:0] row1_s3 [CHANS];
	logic [FW-1:0] f0_s4 [CHANS];
	logic [FW-1:0] f1_s4 [CHANS];
	logic [PIX_W-1:0] pix_s5;

	logic [PIX_W-1:0] p00, p10, p01, p11;
	logic [WW-1:0]    iwx, iwy;

	assign p00 = bank_q[{y0p_s1, x0p_s1}];
	assign p10 = bank_q[{y0p_s1, x1p_s1}];
	assign p01 = bank_q[{y1p_s1, x0p_s1}];
	assign p11 = bank_q[{y1p_s1, x1p_s1}];
	assign iwx = WW'(ONE_W) - WW'(wx_s1);
	assign iwy = WW'(ONE_W) - WW'(wy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= rd_smp;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0p_s1 <= x0[0];
			x1p_s1 <= x1[0];
			y0p_s1 <= y0[0];
			y1p_s1 <= y1[0];
			wx_s1  <= wx;
			wy_s1  <= wy;
			wy_s2  <= wy_s1;
			wy_s3  <= wy_s2;
			for (int c = 0; c < CHANS; c++) begin
				pa_s2[c]   <= PA'(p00[c*CHAN_W +: CHAN_W]) * PA'(iwx);
				pb_s2[c]   <= PA'(p10[c*CHAN_W +: CHAN_W]) * PA'(wx_s1);
				pd_s2[c]   <= PA'(p01[c*CHAN_W +: CHAN_W]) * PA'(iwx);
				pe_s2[c]   <= PA'(p11[c*CHAN_W +: CHAN_W]) * PA'(wx_s1);
				row0_s3[c] <= pa_s2[c] + pb_s2[c];
				row1_s3[c] <= pd_s2[c] + pe_s2[c];
				f0_s4[c]   <= FW'(row0_s3[c]) * FW'(iwy);
				f1_s4[c]   <= FW'(row1_s3[c]) * FW'(wy_s3);
				pix_s5[c*CHAN_W +: CHAN_W] <=
					CHAN_W'((f0_s4[c] + f1_s4[c]) >> (2 * WEIGHT_BITS));
			end
		end
	end

	assign res_vld   = vld_s5;
	assign res_pixel = pix_s5;

endmodule

// File: hdl/bilinear_image_scaler_unit.sv
// Top level of the bilinear image scaler: configuration registers, pipeline control, output skid.
// A sample passes scale multiply, one-bit-per-stage divider, clamp, blend and output stages.
// Throughput: one item per cycle while in_stall is low, loads and samples mixed freely;
//   a load gives no result.
// Reset clears the pipeline and output stages and sets all four size registers to 256;
//   the source store is not cleared and reads of unloaded pixels are undefined.
module bilinear_image_scaler_unit #(
	parameter int MAX_SIDE    = bis_pkg::DEF_MAX_SIDE,
	parameter int WEIGHT_BITS = bis_pkg::DEF_WEIGHT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [bis_pkg::LOAD_COORD_W-1:0] load_x,
	input  logic [bis_pkg::LOAD_COORD_W-1:0] load_y,
	input  logic [bis_pkg::PIX_W-1:0]       load_pixel,
	input  logic [bis_pkg::COORD_W-1:0]     out_x,
	input  logic [bis_pkg::COORD_W-1:0]     out_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bis_pkg::PIX_W-1:0]       out_pixel
);

	import bis_pkg::*;

	localparam int CW = $clog2(MAX_SIDE);

	cfg_t  cfg_q;
	load_t in_load;
	logic  adv, accept;

	logic                   map_vld;
	load_t                  map_load;
	logic [CW-1:0]          x0, x1, y0, y1;
	logic [WEIGHT_BITS-1:0] wx, wy;

	logic             res_vld, res_take;
	logic [PIX_W-1:0] res_pixel;

	logic             out_valid_q, skid_full_q, out_free;
	logic [PIX_W-1:0] out_pixel_q, skid_pixel_q;

	// Config writes are always taken; software must write only when the block is idle; unchecked.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= SRC_SIZE_RST;
			cfg_q.src_height <= SRC_SIZE_RST;
			cfg_q.dst_width  <= DST_SIZE_RST;
			cfg_q.dst_height <= DST_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[SRC_CFG_W-1:0];
				CFG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[SRC_CFG_W-1:0];
				CFG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data[DST_CFG_W-1:0];
				CFG_DST_HEIGHT: cfg_q.dst_height <= cfg_data[DST_CFG_W-1:0];
			endcase
		end
	end

	// The whole pipeline moves as one while the skid stage is empty. A result that
	// meets a stalled output register drops into the skid, which then holds the
	// pipeline (and the input) until the output register drains it.
	assign adv      = !skid_full_q;
	assign in_stall = skid_full_q;
	assign accept   = in_valid && !in_stall;

	assign in_load.mode       = mode_t'(mode);
	assign in_load.load_x     = load_x;
	assign in_load.load_y     = load_y;
	assign in_load.load_pixel = load_pixel;

	bis_map #(
		.MAX_SIDE    (MAX_SIDE),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (accept),
		.in_load  (in_load),
		.in_out_x (out_x),
		.in_out_y (out_y),
		.cfg      (cfg_q),
		.map_vld  (map_vld),
		.map_load (map_load),
		.x0       (x0),
		.x1       (x1),
		.wx       (wx),
		.y0       (y0),
		.y1       (y1),
		.wy       (wy)
	);

	// Loads write the store at the same stage where samples read it, so every
	// sample sees exactly the loads accepted before it.
	bis_blend #(
		.MAX_SIDE    (MAX_SIDE),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.map_vld   (map_vld),
		.map_load  (map_load),
		.x0        (x0),
		.x1        (x1),
		.wx        (wx),
		.y0        (y0),
		.y1        (y1),
		.wy        (wy),
		.res_vld   (res_vld),
		.res_pixel (res_pixel)
	);

	// A result leaves the last blend stage on every advance.
	assign res_take = adv && res_vld;
	// The output register can load when empty or when its transaction completes.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_free) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= res_take;
			end
		end else if (res_take) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_full_q) begin
				out_pixel_q <= skid_pixel_q;
			end else if (res_take) begin
				out_pixel_q <= res_pixel;
			end
		end else if (res_take) begin
			skid_pixel_q <= res_pixel;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;

	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled although the output register was free");

	a_no_result_into_full_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && res_vld) |=> (res_vld && $stable(res_pixel)))
		else $error("last blend stage moved while the skid was full");

endmodule

// File: test/tb.sv
// Self-checking testbench for the bilinear image scaler top level.
`timescale 1ns / 100ps

module tb;
	import bis_pkg::*;

	localparam int MAX_SIDE = DEF_MAX_SIDE;
	localparam int WB = DEF_WEIGHT_BITS;
	localparam longint unsigned ONE_W = longint'(1) << WB;
	// the pipeline is 24 deep at the defaults; leave a margin on top of it
	localparam int LATENCY_PAD = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT = 23;
	localparam int MAX_REPORTS = 20;

	// one pending input transaction; drain marks a hold-off until all pixels are back
	typedef struct packed {
		bit                      drain;
		mode_t                   mode;
		logic [LOAD_COORD_W-1:0] lx;
		logic [LOAD_COORD_W-1:0] ly;
		logic [PIX_W-1:0]        pix;
		logic [COORD_W-1:0]      ox;
		logic [COORD_W-1:0]      oy;
	} scaler_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_SRC_WIDTH;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    mode = MODE_LOAD;
	logic [LOAD_COORD_W-1:0] load_x = '0;
	logic [LOAD_COORD_W-1:0] load_y = '0;
	logic [PIX_W-1:0]        load_pixel = '0;
	logic [COORD_W-1:0]      out_x = '0;
	logic [COORD_W-1:0]      out_y = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [PIX_W-1:0]        out_pixel;

	bilinear_image_scaler_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.load_x     (load_x),
		.load_y     (load_y),
		.load_pixel (load_pixel),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel)
	);

	always #6 clk = ~clk;

	// Shadow state: the size registers as last written, and the source image as loaded.
	logic [SRC_CFG_W-1:0] src_w_reg = SRC_SIZE_RST;
	logic [SRC_CFG_W-1:0] src_h_reg = SRC_SIZE_RST;
	logic [DST_CFG_W-1:0] dst_w_reg = DST_SIZE_RST;
	logic [DST_CFG_W-1:0] dst_h_reg = DST_SIZE_RST;
	logic [PIX_W-1:0]     image_copy [0:MAX_SIDE*MAX_SIDE-1];
	// pixels that the generated stimulus has loaded so far; samples only read these
	bit                   loaded_map [0:MAX_SIDE*MAX_SIDE-1];

	scaler_item_t         scaler_items[$];
	logic [PIX_W-1:0]     expected_pixels[$];
	scaler_item_t         cur_item;
	bit                   steady = 1'b0;
	int                   errors = 0;
	int                   loads_done = 0;
	int                   samples_done = 0;
	int                   pixels_checked = 0;
	int                   settings_run = 0;
	int                   quiet_cycles = 0;

	function automatic longint unsigned eff_src(longint unsigned v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return v;
	endfunction

	// Map one output coordinate onto a source index pair and a fractional weight.
	function automatic void map_axis(input longint unsigned coord, input longint unsigned src_raw,
			input longint unsigned dst_raw, output longint unsigned i0,
			output longint unsigned i1, output longint unsigned w);
		longint unsigned src, dst, pos, top;
		src = eff_src(src_raw);
		dst = (dst_raw == 0) ? 1 : dst_raw;
		pos = (coord * src * ONE_W) / dst;
		top = (src - 1) * ONE_W;
		// beyond the image: pin to the last column or row with zero weight
		if (pos > top)
			pos = top;
		i0 = pos >> WB;
		w = pos & (ONE_W - 1);
		i1 = (i0 + 1 < src) ? i0 + 1 : src - 1;
	endfunction

	function automatic logic [PIX_W-1:0] blend_pixel(logic [COORD_W-1:0] ox,
			logic [COORD_W-1:0] oy);
		longint unsigned x0, x1, wx, y0, y1, wy, row0, row1, v;
		logic [PIX_W-1:0] p00, p10, p01, p11, res;
		map_axis(64'(ox), 64'(src_w_reg), 64'(dst_w_reg), x0, x1, wx);
		map_axis(64'(oy), 64'(src_h_reg), 64'(dst_h_reg), y0, y1, wy);
		p00 = image_copy[y0 * MAX_SIDE + x0];
		p10 = image_copy[y0 * MAX_SIDE + x1];
		p01 = image_copy[y1 * MAX_SIDE + x0];
		p11 = image_copy[y1 * MAX_SIDE + x1];
		res = '0;
		for (int c = 0; c < CHANS; c++) begin
			row0 = p00[c*CHAN_W +: CHAN_W] * (ONE_W - wx) + p10[c*CHAN_W +: CHAN_W] * wx;
			row1 = p01[c*CHAN_W +: CHAN_W] * (ONE_W - wx) + p11[c*CHAN_W +: CHAN_W] * wx;
			v = (row0 * (ONE_W - wy) + row1 * wy) >> (2 * WB);
			res[c*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
		end
		return res;
	endfunction

	function automatic bit neighbours_loaded(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
		longint unsigned x0, x1, wx, y0, y1, wy;
		map_axis(64'(ox), 64'(src_w_reg), 64'(dst_w_reg), x0, x1, wx);
		map_axis(64'(oy), 64'(src_h_reg), 64'(dst_h_reg), y0, y1, wy);
		return loaded_map[y0 * MAX_SIDE + x0] && loaded_map[y0 * MAX_SIDE + x1] &&
			loaded_map[y1 * MAX_SIDE + x0] && loaded_map[y1 * MAX_SIDE + x1];
	endfunction

	// Build a load transaction; the unused sample fields carry noise.
	function automatic scaler_item_t load_item(int x, int y, logic [PIX_W-1:0] pix);
		scaler_item_t it;
		it.drain = 1'b0;
		it.mode = MODE_LOAD;
		it.lx = x[LOAD_COORD_W-1:0];
		it.ly = y[LOAD_COORD_W-1:0];
		it.pix = pix;
		it.ox = COORD_W'($urandom);
		it.oy = COORD_W'($urandom);
		loaded_map[it.ly * MAX_SIDE + it.lx] = 1'b1;
		return it;
	endfunction

	function automatic scaler_item_t sample_item(int x, int y);
		scaler_item_t it;
		it = load_item(0, 0, 0);
		it.mode = MODE_SAMPLE;
		it.lx = LOAD_COORD_W'($urandom);
		it.ly = LOAD_COORD_W'($urandom);
		it.pix = $urandom;
		it.ox = x[COORD_W-1:0];
		it.oy = y[COORD_W-1:0];
		return it;
	endfunction

	// Random transaction: loads now and then, otherwise samples aimed at the loaded block.
	function automatic scaler_item_t random_item(int bx, int bw, int by, int bh,
			int esw, int esh, int edw, int edh);
		scaler_item_t it;
		int lo_x, hi_x, lo_y, hi_y;
		if ($urandom_range(99, 0) < 30) begin
			if ($urandom_range(1, 0))
				return load_item(bx + $urandom_range(bw - 1, 0), by + $urandom_range(bh - 1, 0),
					$urandom);
			return load_item($urandom_range(MAX_SIDE - 1, 0), $urandom_range(MAX_SIDE - 1, 0),
				$urandom);
		end
		lo_x = bx * edw / esw;
		hi_x = ((bx + bw) * edw / esw + 1 > 4095) ? 4095 : (bx + bw) * edw / esw + 1;
		lo_y = by * edh / esh;
		hi_y = ((by + bh) * edh / esh + 1 > 4095) ? 4095 : (by + bh) * edh / esh + 1;
		for (int tries = 0; tries < 40; tries++) begin
			if ($urandom_range(9, 0) == 0)
				it = sample_item($urandom_range(4095, 0), $urandom_range(4095, 0));
			else
				it = sample_item($urandom_range(hi_x, lo_x), $urandom_range(hi_y, lo_y));
			if (neighbours_loaded(it.ox, it.oy))
				return it;
		end
		// nothing readable found: fall back to a load anywhere
		return load_item($urandom_range(MAX_SIDE - 1, 0), $urandom_range(MAX_SIDE - 1, 0),
			$urandom);
	endfunction

	// Advance the shadow image, or queue the pixel that a sample should return.
	function automatic void apply_item(scaler_item_t it);
		if (it.mode == MODE_LOAD) begin
			image_copy[it.ly * MAX_SIDE + it.lx] = it.pix;
			loads_done++;
		end else begin
			expected_pixels.push_back(blend_pixel(it.ox, it.oy));
			samples_done++;
		end
	endfunction

	// Input driver: hold a stalled transaction, otherwise present the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				apply_item(cur_item);
			if (!in_valid || !in_stall) begin
				// drop a hold-off marker once every expected pixel has come back
				if (scaler_items.size() != 0 && scaler_items[0].drain &&
						expected_pixels.size() == 0)
					scaler_items.delete(0);
				if (scaler_items.size() != 0 && !scaler_items[0].drain &&
						(steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
					cur_item = scaler_items.pop_front();
					in_valid <= 1'b1;
					mode <= cur_item.mode;
					load_x <= cur_item.lx;
					load_y <= cur_item.ly;
					load_pixel <= cur_item.pix;
					out_x <= cur_item.ox;
					out_y <= cur_item.oy;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each accepted pixel against the oldest expectation, stall at random.
	always @(posedge clk or negedge arst_n) begin
		logic [PIX_W-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				pixels_checked++;
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: out_pixel expected none, got %h", $time, out_pixel);
				end else begin
					want = expected_pixels.pop_front();
					if (out_pixel !== want) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: out_pixel expected %h, got %h", $time, want,
								out_pixel);
					end
				end
			end
			out_stall <= !steady && ($urandom_range(99, 0) < IDLE_PCT);
		end
	end

	// Watchdog: end the run if no transaction of any kind moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Wait until every queued transaction has gone and every pixel is back, then let
	// trailing loads clear the pipeline before touching the size registers.
	task automatic settle();
		while (scaler_items.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	// Write one size register; leaves cfg_valid high so writes run back to back.
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_SRC_WIDTH:  src_w_reg = data[SRC_CFG_W-1:0];
			CFG_SRC_HEIGHT: src_h_reg = data[SRC_CFG_W-1:0];
			CFG_DST_WIDTH:  dst_w_reg = data;
			CFG_DST_HEIGHT: dst_h_reg = data;
			default: ;
		endcase
	endtask

	// One size setting: reprogram while idle, load a block of the source, then queue
	// random traffic, optionally with a hold-off half way through.
	task automatic run_setting(logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] sh,
			logic [CFG_DATA_W-1:0] dw, logic [CFG_DATA_W-1:0] dh, int nrand,
			bit pause_mid, bit calm);
		int esw, esh, edw, edh, bw, bh, bx, by;
		scaler_item_t marker;
		settle();
		write_reg(CFG_SRC_WIDTH, sw);
		write_reg(CFG_SRC_HEIGHT, sh);
		write_reg(CFG_DST_WIDTH, dw);
		write_reg(CFG_DST_HEIGHT, dh);
		cfg_valid <= 1'b0;
		steady = calm;
		settings_run++;
		esw = int'(eff_src(64'(src_w_reg)));
		esh = int'(eff_src(64'(src_h_reg)));
		edw = (dst_w_reg == 0) ? 1 : int'(dst_w_reg);
		edh = (dst_h_reg == 0) ? 1 : int'(dst_h_reg);
		bw = (esw < 6) ? esw : 6;
		bh = (esh < 6) ? esh : 6;
		// put the block at the origin, at the far edge or anywhere
		case ($urandom_range(2, 0))
			0: begin bx = 0; by = 0; end
			1: begin bx = esw - bw; by = esh - bh; end
			default: begin
				bx = $urandom_range(esw - bw, 0);
				by = $urandom_range(esh - bh, 0);
			end
		endcase
		for (int y = by; y < by + bh; y++)
			for (int x = bx; x < bx + bw; x++)
				scaler_items.push_back(load_item(x, y, $urandom));
		marker = load_item(0, 0, 0);
		marker.drain = 1'b1;
		for (int i = 0; i < nrand; i++) begin
			if (pause_mid && i == nrand / 2)
				scaler_items.push_back(marker);
			scaler_items.push_back(random_item(bx, bw, by, bh, esw, esh, edw, edh));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: corner pixels at the channel extremes, integer positions,
		// the last column and row, and coordinates far beyond the image.
		scaler_items.push_back(load_item(0, 0, 32'h0000_0000));
		scaler_items.push_back(load_item(1, 0, 32'hFFFF_FFFF));
		scaler_items.push_back(load_item(0, 1, 32'h80FF_017F));
		scaler_items.push_back(load_item(1, 1, 32'h0102_FEFD));
		scaler_items.push_back(load_item(254, 254, $urandom));
		scaler_items.push_back(load_item(255, 254, $urandom));
		scaler_items.push_back(load_item(254, 255, $urandom));
		scaler_items.push_back(load_item(255, 255, 32'hFFFF_FFFF));
		scaler_items.push_back(sample_item(0, 0));
		scaler_items.push_back(sample_item(254, 254));
		scaler_items.push_back(sample_item(255, 255));
		scaler_items.push_back(sample_item(4095, 4095));
		scaler_items.push_back(sample_item(255, 4095));

		// 2x2 up to 3x3: fractional weights on both axes, neighbour clamped at the edge
		run_setting(2, 2, 3, 3, 0, 1'b0, 1'b0);
		scaler_items.push_back(sample_item(0, 0));
		scaler_items.push_back(sample_item(1, 1));
		scaler_items.push_back(sample_item(2, 2));
		scaler_items.push_back(sample_item(2, 0));
		scaler_items.push_back(sample_item(4095, 4095));

		// zero sizes behave as one pixel
		run_setting(0, 0, 0, 0, 60, 1'b0, 1'b0);
		// high bits on a source width are dropped; oversized source and top destination sizes
		run_setting(13'h1E03, 511, 8191, 4096, 60, 1'b1, 1'b0);
		run_setting(256, 256, 4096, 4096, 60, 1'b0, 1'b0);
		run_setting(256, 256, 1, 1, 60, 1'b0, 1'b0);
		run_setting(1, 256, 4096, 1, 60, 1'b0, 1'b0);
		// hold both sides busy for one whole setting
		run_setting(7, 5, 13, 11, 60, 1'b0, 1'b1);
		for (int p = 0; p < 4; p++)
			run_setting(CFG_DATA_W'($urandom_range(24, 1)), CFG_DATA_W'($urandom_range(24, 1)),
				CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(4096, 1) :
					$urandom_range(64, 1)),
				CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(4096, 1) :
					$urandom_range(64, 1)),
				60, 1'b0, 1'b0);

		settle();
		if (expected_pixels.size() != 0)
			errors++;
		$display("tb: %0d loads and %0d samples over %0d size settings", loads_done,
			samples_done, settings_run);
		$display("tb: %0d output pixels checked, %0d mismatches", pixels_checked, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
